FILE: hw/rtl/jsu_pkg.sv
// Shared types, character codes and helper functions for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

    localparam logic [7:0]  CHAR_EOT    = 8'h00;
    localparam logic [7:0]  CHAR_QUOTE  = 8'h22;
    localparam logic [7:0]  CHAR_BSLASH = 8'h5C;
    localparam logic [7:0]  CHAR_U      = 8'h75;
    localparam logic [7:0]  CHAR_QMARK  = 8'h3F;
    localparam logic [15:0] ASCII_LIMIT = 16'd128;
    localparam logic [1:0]  HEX_LAST    = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_QUOTE = 2'd1,
        KIND_EOT   = 2'd2,
        KIND_REJ   = 2'd3
    } kind_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  digit_count;
        logic [15:0] code_acc;
        logic        truncated;
    } state_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic logic [7:0] escape_byte(input logic [7:0] c);
        logic [7:0] v;
        unique case (c)
            8'h6E:   v = 8'd10;
            8'h72:   v = 8'd13;
            8'h74:   v = 8'd9;
            8'h62:   v = 8'd8;
            8'h66:   v = 8'd12;
            default: v = c;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] code_byte(input logic [15:0] code);
        return (code < ASCII_LIMIT) ? code[7:0] : CHAR_QMARK;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/json_string_unescaper.sv
// Top level of the JSON string unescaper: input register, parser state and result queue.
//
//  Channel   Direction  Payload                                    Per request
//  s_axis    in         tdata[7:0] in_byte                         one text byte
//  m_axis    out        tdata[7:0] out_byte, tuser[1:0] kind, tlast  one result
//
// A byte is decoded in the cycle after it is taken, and its results enter the four-entry
// result queue at the first edge with room; results are offered from the queue registers.
// With a ready output side one byte is taken per cycle; the two results of end of text in
// a \u escape are absorbed by the queue. Synchronous active-low reset returns the parser to
// idle and empties the queue. A stalled output side fills the queue, after which the input
// register holds and s_axis_tready drops until there is room again.
`default_nettype none

module json_string_unescaper (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]      m_axis_tuser,   // [1:0] kind
    output logic            m_axis_tlast
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        in_byte_reg;
    jsu_pkg::state_t   state_reg;
    jsu_pkg::state_t   state_next;
    jsu_pkg::push_t    push;
    jsu_pkg::result_t  out_res;
    logic              push_ok;
    logic              fire;
    logic              s_accept;

    jsu_decode u_decode (
        .in_byte    (in_byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .push       (push)
    );

    jsu_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (fire),
        .push      (push),
        .push_ok   (push_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign fire          = in_valid_reg && push_ok;
    assign s_axis_tready = !in_valid_reg || push_ok;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    assign m_axis_tdata = out_res.data;
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{jsu_pkg::MODE_IDLE, 2'd0, 16'd0, 1'b0};
        end else begin
            in_valid_reg <= in_valid_next;
            if (fire) begin
                state_reg <= state_next;
            end
        end
        if (s_accept) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !push_ok) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending byte lost while the result queue was full");

    a_state_on_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(state_reg))
        else $error("parser state changed without a decoded byte");

    a_two_only_hex_eot: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count == 2'd2) |-> (state_reg.mode == jsu_pkg::MODE_HEX
                                  && in_byte_reg == jsu_pkg::CHAR_EOT))
        else $error("two results decoded outside end of text in a code escape");

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_decode.sv
// Combinational decoder: next parser state and up to two results for one text byte.
`default_nettype none

module jsu_decode (
    input  wire logic [7:0]     in_byte,
    input  jsu_pkg::state_t     state,
    output jsu_pkg::state_t     state_next,
    output jsu_pkg::push_t      push
);

    localparam jsu_pkg::result_t RES_NONE = '{8'd0, jsu_pkg::KIND_DATA, 1'b0};
    localparam jsu_pkg::result_t RES_EOT  = '{8'd0, jsu_pkg::KIND_EOT, 1'b1};

    logic [3:0]  nib;
    logic [15:0] code_shift;
    logic [7:0]  cb_cur;
    logic [7:0]  cb_new;
    logic [7:0]  esc;

    assign nib        = jsu_pkg::hex_value(in_byte);
    assign code_shift = {state.code_acc[11:0], nib};
    assign cb_cur     = jsu_pkg::code_byte(state.code_acc);
    assign cb_new     = jsu_pkg::code_byte(code_shift);
    assign esc        = jsu_pkg::escape_byte(in_byte);

    // Next state.
    always_comb begin
        state_next = state;
        unique case (state.mode)
            jsu_pkg::MODE_IDLE: begin
                if (in_byte == jsu_pkg::CHAR_QUOTE) begin
                    state_next.mode      = jsu_pkg::MODE_STR;
                    state_next.truncated = 1'b0;
                end
            end
            jsu_pkg::MODE_STR: begin
                if (in_byte == jsu_pkg::CHAR_EOT || in_byte == jsu_pkg::CHAR_QUOTE) begin
                    state_next.mode = jsu_pkg::MODE_IDLE;
                end else if (in_byte == jsu_pkg::CHAR_BSLASH) begin
                    state_next.mode = jsu_pkg::MODE_ESC;
                end
            end
            jsu_pkg::MODE_ESC: begin
                if (in_byte == jsu_pkg::CHAR_EOT) begin
                    state_next.mode = jsu_pkg::MODE_IDLE;
                end else if (in_byte == jsu_pkg::CHAR_U) begin
                    state_next.mode        = jsu_pkg::MODE_HEX;
                    state_next.digit_count = 2'd0;
                    state_next.code_acc    = 16'd0;
                end else begin
                    state_next.mode = jsu_pkg::MODE_STR;
                    if (esc == 8'd0) begin
                        state_next.truncated = 1'b1;
                    end
                end
            end
            jsu_pkg::MODE_HEX: begin
                if (in_byte == jsu_pkg::CHAR_EOT) begin
                    state_next.mode = jsu_pkg::MODE_IDLE;
                    if (cb_cur == 8'd0) begin
                        state_next.truncated = 1'b1;
                    end
                end else begin
                    state_next.code_acc = code_shift;
                    if (state.digit_count == jsu_pkg::HEX_LAST) begin
                        state_next.mode        = jsu_pkg::MODE_STR;
                        state_next.digit_count = 2'd0;
                        if (cb_new == 8'd0) begin
                            state_next.truncated = 1'b1;
                        end
                    end else begin
                        state_next.digit_count = state.digit_count + 2'd1;
                    end
                end
            end
            default: state_next = state;
        endcase
    end

    // Results.
    always_comb begin
        push.count = 2'd0;
        push.r0    = RES_NONE;
        push.r1    = RES_NONE;
        unique case (state.mode)
            jsu_pkg::MODE_IDLE: begin
                if (in_byte != jsu_pkg::CHAR_QUOTE) begin
                    push.count = 2'd1;
                    push.r0    = '{8'd0, jsu_pkg::KIND_REJ, 1'b1};
                end
            end
            jsu_pkg::MODE_STR: begin
                if (in_byte == jsu_pkg::CHAR_EOT) begin
                    push.count = 2'd1;
                    push.r0    = RES_EOT;
                end else if (in_byte == jsu_pkg::CHAR_QUOTE) begin
                    push.count = 2'd1;
                    push.r0    = '{8'd0, jsu_pkg::KIND_QUOTE, 1'b1};
                end else if (in_byte != jsu_pkg::CHAR_BSLASH && !state.truncated) begin
                    push.count = 2'd1;
                    push.r0    = '{in_byte, jsu_pkg::KIND_DATA, 1'b0};
                end
            end
            jsu_pkg::MODE_ESC: begin
                if (in_byte == jsu_pkg::CHAR_EOT) begin
                    push.count = 2'd1;
                    push.r0    = RES_EOT;
                end else if (in_byte != jsu_pkg::CHAR_U && !state.truncated && esc != 8'd0) begin
                    push.count = 2'd1;
                    push.r0    = '{esc, jsu_pkg::KIND_DATA, 1'b0};
                end
            end
            jsu_pkg::MODE_HEX: begin
                if (in_byte == jsu_pkg::CHAR_EOT) begin
                    if (!state.truncated && cb_cur != 8'd0) begin
                        push.count = 2'd2;
                        push.r0    = '{cb_cur, jsu_pkg::KIND_DATA, 1'b0};
                        push.r1    = RES_EOT;
                    end else begin
                        push.count = 2'd1;
                        push.r0    = RES_EOT;
                    end
                end else if (state.digit_count == jsu_pkg::HEX_LAST && !state.truncated
                             && cb_new != 8'd0) begin
                    push.count = 2'd1;
                    push.r0    = '{cb_new, jsu_pkg::KIND_DATA, 1'b0};
                end
            end
            default: push.count = 2'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_out_queue.sv
// Shifting result queue that takes up to two results per cycle while there is room and hands out one.
`default_nettype none

module jsu_out_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_en,
    input  jsu_pkg::push_t       push,
    output logic                 push_ok,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output jsu_pkg::result_t     out_res
);

    jsu_pkg::result_t ent_reg   [jsu_pkg::QUEUE_DEPTH];
    jsu_pkg::result_t ent_next  [jsu_pkg::QUEUE_DEPTH];
    jsu_pkg::result_t shifted   [jsu_pkg::QUEUE_DEPTH];
    logic [jsu_pkg::QUEUE_CW-1:0] count_reg;
    logic [jsu_pkg::QUEUE_CW-1:0] count_next;
    logic [jsu_pkg::QUEUE_CW-1:0] base;
    logic [jsu_pkg::QUEUE_CW-1:0] base1;
    logic [jsu_pkg::QUEUE_CW:0]   fill;
    logic                         pop;

    assign out_valid = (count_reg != '0);
    assign out_res   = ent_reg[0];
    assign pop       = out_valid && out_ready;
    assign base      = count_reg - jsu_pkg::QUEUE_CW'(pop);
    assign base1     = base + jsu_pkg::QUEUE_CW'(1);
    assign fill      = {1'b0, base} + (jsu_pkg::QUEUE_CW + 1)'(push.count);
    assign push_ok   = (fill <= (jsu_pkg::QUEUE_CW + 1)'(jsu_pkg::QUEUE_DEPTH));

    always_comb begin
        for (int i = 0; i < jsu_pkg::QUEUE_DEPTH - 1; i++) begin
            shifted[i] = pop ? ent_reg[i + 1] : ent_reg[i];
        end
        shifted[jsu_pkg::QUEUE_DEPTH - 1] = ent_reg[jsu_pkg::QUEUE_DEPTH - 1];
        for (int i = 0; i < jsu_pkg::QUEUE_DEPTH; i++) begin
            ent_next[i] = shifted[i];
            if (push_en && push.count != 2'd0 && base == jsu_pkg::QUEUE_CW'(i)) begin
                ent_next[i] = push.r0;
            end
            if (push_en && push.count == 2'd2 && base1 == jsu_pkg::QUEUE_CW'(i)) begin
                ent_next[i] = push.r1;
            end
        end
        count_next = push_en ? fill[jsu_pkg::QUEUE_CW-1:0] : base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        ent_reg <= ent_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= jsu_pkg::QUEUE_CW'(jsu_pkg::QUEUE_DEPTH))
        else $error("result queue holds more entries than its depth");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push_en |-> push_ok)
        else $error("results pushed without room in the queue");

endmodule

`default_nettype wire

FILE: tb/sv/json_string_unescaper_tb.sv
// Self-checking testbench for the JSON string unescaper, predicting results byte by byte.
`default_nettype none

module json_string_unescaper_tb;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DIRECTED_BYTES = 26;
    localparam int         PHASE_BYTES    = 256;
    localparam int         REPORT_LIMIT   = 10;
    localparam logic [7:0] CH_SLASH       = "/";
    localparam logic [7:0] CH_N           = "n";
    localparam logic [7:0] CH_R           = "r";
    localparam logic [7:0] CH_T           = "t";
    localparam logic [7:0] CH_B           = "b";
    localparam logic [7:0] CH_F           = "f";

    class unescape_predictor;
        jsu_pkg::mode_t   mode;
        logic [1:0]       digits;
        logic [15:0]      code;
        bit               truncated;
        jsu_pkg::result_t expected_results[$];
        int               mismatches;
        int               kind_count[4];

        function new();
            mode = jsu_pkg::MODE_IDLE;
            digits = 2'd0;
            code = 16'd0;
            truncated = 1'b0;
            mismatches = 0;
            kind_count = '{0, 0, 0, 0};
        endfunction

        function logic [3:0] hex_nibble(logic [7:0] c);
            if (c >= "0" && c <= "9") begin
                return 4'(c - "0");
            end else if (c >= "a" && c <= "f") begin
                return 4'(c - "a" + 10);
            end else if (c >= "A" && c <= "F") begin
                return 4'(c - "A" + 10);
            end
            return 4'd0;
        endfunction

        function logic [7:0] unescaped(logic [7:0] c);
            case (c)
                CH_N:    return 8'd10;
                CH_R:    return 8'd13;
                CH_T:    return 8'd9;
                CH_B:    return 8'd8;
                CH_F:    return 8'd12;
                default: return c;
            endcase
        endfunction

        function logic [7:0] code_as_byte();
            return (code < 16'd128) ? code[7:0] : jsu_pkg::CHAR_QMARK;
        endfunction

        function void add_data(logic [7:0] b);
            if (truncated) begin
                return;
            end
            if (b == 8'd0) begin
                truncated = 1'b1;
            end else begin
                expected_results.push_back(
                    jsu_pkg::result_t'{data: b, kind: jsu_pkg::KIND_DATA, last: 1'b0});
            end
        endfunction

        function void add_end(jsu_pkg::kind_t k);
            expected_results.push_back(jsu_pkg::result_t'{data: 8'd0, kind: k, last: 1'b1});
        endfunction

        function void note_byte(logic [7:0] c);
            case (mode)
                jsu_pkg::MODE_IDLE: begin
                    if (c == jsu_pkg::CHAR_QUOTE) begin
                        mode = jsu_pkg::MODE_STR;
                        truncated = 1'b0;
                    end else begin
                        add_end(jsu_pkg::KIND_REJ);
                    end
                end
                jsu_pkg::MODE_STR: begin
                    if (c == jsu_pkg::CHAR_EOT) begin
                        add_end(jsu_pkg::KIND_EOT);
                        mode = jsu_pkg::MODE_IDLE;
                    end else if (c == jsu_pkg::CHAR_QUOTE) begin
                        add_end(jsu_pkg::KIND_QUOTE);
                        mode = jsu_pkg::MODE_IDLE;
                    end else if (c == jsu_pkg::CHAR_BSLASH) begin
                        mode = jsu_pkg::MODE_ESC;
                    end else begin
                        add_data(c);
                    end
                end
                jsu_pkg::MODE_ESC: begin
                    if (c == jsu_pkg::CHAR_EOT) begin
                        add_end(jsu_pkg::KIND_EOT);
                        mode = jsu_pkg::MODE_IDLE;
                    end else if (c == jsu_pkg::CHAR_U) begin
                        digits = 2'd0;
                        code = 16'd0;
                        mode = jsu_pkg::MODE_HEX;
                    end else begin
                        add_data(unescaped(c));
                        mode = jsu_pkg::MODE_STR;
                    end
                end
                default: begin
                    if (c == jsu_pkg::CHAR_EOT) begin
                        add_data(code_as_byte());
                        add_end(jsu_pkg::KIND_EOT);
                        mode = jsu_pkg::MODE_IDLE;
                    end else begin
                        code = {code[11:0], hex_nibble(c)};
                        if (digits == jsu_pkg::HEX_LAST) begin
                            add_data(code_as_byte());
                            digits = 2'd0;
                            mode = jsu_pkg::MODE_STR;
                        end else begin
                            digits = digits + 2'd1;
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(logic [7:0] data, logic [1:0] kind, logic last);
            jsu_pkg::result_t want;
            kind_count[kind]++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Unexpected result: data %02h kind %0d last %0b",
                             data, kind, last);
                end
                return;
            end
            want = expected_results.pop_front();
            if (data !== want.data || kind !== want.kind || last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Mismatch: expected data %02h kind %0d last %0b, got %02h %0d %0b",
                             want.data, want.kind, want.last, data, kind, last);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    unescape_predictor predictor = new();
    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    int  bytes_sent = 0;
    int  quiet_cycles = 0;
    bit  progress;

    json_string_unescaper u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            progress = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                predictor.note_byte(s_axis_tdata);
                progress = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                predictor.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
                progress = 1'b1;
            end
            if (progress) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("No request accepted for %0d cycles.", WATCHDOG_LIMIT);
                    $display("json_string_unescaper_tb failed");
                    $finish;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (predictor.pending() != 0) begin
            @(negedge aclk);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'("0" + n);
        end
        return $urandom_range(1) ? 8'("a" + n - 10) : 8'("A" + n - 10);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255, 1));
        end while (b == jsu_pkg::CHAR_QUOTE || b == jsu_pkg::CHAR_BSLASH);
        return b;
    endfunction

    task automatic send_unicode_escape(input int cut_after);
        logic [15:0] value;
        int          style;
        int          k;
        style = $urandom_range(7);
        case (style)
            0:       value = 16'd0;
            1, 2, 3: value = 16'($urandom_range(127));
            default: value = 16'($urandom);
        endcase
        send_byte(jsu_pkg::CHAR_BSLASH);
        send_byte(jsu_pkg::CHAR_U);
        for (k = 0; k < 4 && k < cut_after; k++) begin
            if (style == 7 && $urandom_range(1)) begin
                send_byte(8'($urandom_range(255, 1)));
            end else begin
                send_byte(hex_char(value[15 - 4 * k -: 4]));
            end
        end
    endtask

    task automatic send_random_string();
        logic [7:0] escapes[8];
        int         n_elems;
        int         e;
        int         sel;
        escapes = '{jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BSLASH, CH_SLASH, CH_N, CH_R, CH_T,
                    CH_B, CH_F};
        if ($urandom_range(9) == 0) begin
            send_byte(8'($urandom));
            return;
        end
        send_byte(jsu_pkg::CHAR_QUOTE);
        n_elems = $urandom_range(12);
        for (e = 0; e < n_elems; e++) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                send_byte(plain_byte());
            end else if (sel < 75) begin
                send_byte(jsu_pkg::CHAR_BSLASH);
                if ($urandom_range(3) == 0) begin
                    send_byte(8'($urandom_range(255, 1)));
                end else begin
                    send_byte(escapes[$urandom_range(7)]);
                end
            end else begin
                send_unicode_escape(4);
            end
        end
        sel = $urandom_range(19);
        if (sel == 0) begin
            send_byte(jsu_pkg::CHAR_BSLASH);
            send_byte(jsu_pkg::CHAR_EOT);
        end else if (sel == 1) begin
            send_unicode_escape($urandom_range(3));
            send_byte(jsu_pkg::CHAR_EOT);
        end else if (sel == 2) begin
            send_byte(jsu_pkg::CHAR_EOT);
        end else begin
            send_byte(jsu_pkg::CHAR_QUOTE);
        end
    endtask

    initial begin
        logic [7:0] opening_bytes[$];
        int         sender_idle[4];
        int         receiver_stall[4];
        int         phase;
        opening_bytes = '{8'hFF, jsu_pkg::CHAR_EOT, jsu_pkg::CHAR_QUOTE, 8'hFF,
                          jsu_pkg::CHAR_BSLASH, jsu_pkg::CHAR_QUOTE,
                          jsu_pkg::CHAR_BSLASH, CH_N, jsu_pkg::CHAR_BSLASH, jsu_pkg::CHAR_U,
                          "0", "0", "7", "e",
                          jsu_pkg::CHAR_BSLASH, jsu_pkg::CHAR_U, "F", jsu_pkg::CHAR_QUOTE,
                          "g", "A", jsu_pkg::CHAR_QUOTE,
                          jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BSLASH, jsu_pkg::CHAR_U, "4",
                          jsu_pkg::CHAR_EOT};
        sender_idle = '{0, 77, 0, 6};
        receiver_stall = '{0, 0, 77, 6};

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (opening_bytes[i]) begin
            send_byte(opening_bytes[i]);
        end

        for (phase = 0; phase < 4; phase++) begin
            sender_idle_pct = sender_idle[phase];
            receiver_stall_pct = receiver_stall[phase];
            while (bytes_sent < DIRECTED_BYTES + (phase + 1) * PHASE_BYTES) begin
                send_random_string();
            end
            if (phase == 1) begin
                hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (16) @(negedge aclk);

        $display("Sent %0d text bytes over four idle and stall mixes.", bytes_sent);
        $display("Saw %0d decoded bytes, %0d quote ends, %0d end-of-text ends, %0d rejects.",
                 predictor.kind_count[jsu_pkg::KIND_DATA],
                 predictor.kind_count[jsu_pkg::KIND_QUOTE],
                 predictor.kind_count[jsu_pkg::KIND_EOT],
                 predictor.kind_count[jsu_pkg::KIND_REJ]);
        if (predictor.mismatches == 0 && predictor.pending() == 0) begin
            $display("json_string_unescaper_tb passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived.",
                     predictor.mismatches, predictor.pending());
            $display("json_string_unescaper_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
